@@ src/csp_pkg.sv @@
// ----------------------------------------------------------------------------
// csp_pkg
// shared types, codes and defaults of the cubic sample player
// ----------------------------------------------------------------------------
package csp_pkg;

	localparam int DEF_SAMPLE_DEPTH = 65536;
	localparam int DEF_SAMPLE_BITS  = 16;
	localparam int DEF_FRAC_BITS    = 16;

	localparam int POS_BITS       = 40;
	localparam int QUEUE_DEPTH    = 4;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;
	localparam int FRAMES_BITS    = 17;

	localparam logic [FRAMES_BITS-1:0] RST_SAMPLE_FRAMES  = '0;
	localparam logic                   RST_STEREO_MODE    = 1'b1;
	localparam logic [31:0]            RST_POSITION_STEP  = 32'h0001_0000;
	localparam logic [31:0]            RST_START_POSITION = '0;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SAMPLE_FRAMES  = 2'd0,
		REG_STEREO_MODE    = 2'd1,
		REG_POSITION_STEP  = 2'd2,
		REG_START_POSITION = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_RESTART = 2'd1,
		OP_PRODUCE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_ZERO   = 2'd0,
		KIND_BARE   = 2'd1,
		KIND_LINEAR = 2'd2,
		KIND_CUBIC  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_READ   = 3'd1,
		ST_STEP1  = 3'd2,
		ST_STEP2  = 3'd3,
		ST_STEP3  = 3'd4,
		ST_FINISH = 3'd5
	} state_t;

	typedef struct packed {
		logic [FRAMES_BITS-1:0] sample_frames;
		logic                   stereo_mode;
		logic [31:0]            position_step;
		logic [31:0]            start_position;
	} cfg_t;

endpackage

@@ src/csp_front.sv @@
// ----------------------------------------------------------------------------
// csp_front
// input side: decodes each beat, drops idle codes and out-of-store writes,
// trims the lanes to the sample width and packs a command for the queue
// ----------------------------------------------------------------------------
module csp_front #(
	parameter int SAMPLE_DEPTH = csp_pkg::DEF_SAMPLE_DEPTH,
	parameter int SAMPLE_BITS  = csp_pkg::DEF_SAMPLE_BITS,
	parameter int ADDR_BITS    = $clog2(SAMPLE_DEPTH),
	parameter int ENTRY_BITS   = 2 + ADDR_BITS + 2 * SAMPLE_BITS
) (
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            opcode,
	input  logic [15:0]           frame_address,
	input  logic signed [15:0]    left_sample,
	input  logic signed [15:0]    right_sample,
	input  logic                  queue_full,
	output logic                  push_valid,
	output logic [ENTRY_BITS-1:0] push_data
);

	logic                   keep;
	logic [SAMPLE_BITS-1:0] left_trim;
	logic [SAMPLE_BITS-1:0] right_trim;

	always_comb begin
		left_trim  = SAMPLE_BITS'({16'b0, left_sample});
		right_trim = SAMPLE_BITS'({16'b0, right_sample});
		case (opcode)
			csp_pkg::OP_WRITE: begin
				keep = (32'(frame_address) < 32'(SAMPLE_DEPTH));
			end
			csp_pkg::OP_RESTART: begin
				keep = 1'b1;
			end
			csp_pkg::OP_PRODUCE: begin
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall   = queue_full;
	assign push_valid = in_valid && keep;
	assign push_data  = {opcode, ADDR_BITS'(frame_address), left_trim, right_trim};

endmodule

@@ src/csp_fifo.sv @@
// ----------------------------------------------------------------------------
// csp_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module csp_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_BITS = $clog2(csp_pkg::QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(csp_pkg::QUEUE_DEPTH + 1);

	logic [WIDTH-1:0]    slot_q [csp_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full      = (count_q == CNT_BITS'(csp_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ src/csp_back.sv @@
// ----------------------------------------------------------------------------
// csp_back
// execution side: sample store, play position, four-frame fetch, the
// three-step cubic or one-step linear evaluation and the result register
// ----------------------------------------------------------------------------
module csp_back #(
	parameter int SAMPLE_DEPTH = csp_pkg::DEF_SAMPLE_DEPTH,
	parameter int SAMPLE_BITS  = csp_pkg::DEF_SAMPLE_BITS,
	parameter int FRAC_BITS    = csp_pkg::DEF_FRAC_BITS,
	parameter int ADDR_BITS    = $clog2(SAMPLE_DEPTH),
	parameter int ENTRY_BITS   = 2 + ADDR_BITS + 2 * SAMPLE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csp_pkg::cfg_t         cfg,
	input  logic                  q_valid,
	input  logic [ENTRY_BITS-1:0] q_data,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [15:0]    left_out,
	output logic signed [15:0]    right_out,
	output logic                  in_range
);

	localparam int SB = SAMPLE_BITS;
	localparam int FB = FRAC_BITS;
	localparam int W  = SB + 6;
	localparam int PW = W + FB + 1;
	localparam int PB = csp_pkg::POS_BITS;
	localparam int IW = PB - FB;
	localparam int FW = csp_pkg::FRAMES_BITS;
	localparam logic signed [W-1:0]  SAT_HI   = W'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [W-1:0]  SAT_LO   = ~SAT_HI;
	localparam logic signed [PW-1:0] RND_HALF = PW'(64'sd1 <<< (FB - 1));

	csp_pkg::state_t state_q, state_d;

	// store
	logic [2*SB-1:0]      mem [SAMPLE_DEPTH];
	logic [2*SB-1:0]      rd_q;
	logic [ADDR_BITS-1:0] rd_addr;
	logic                 mem_we;

	// queue entry
	csp_pkg::op_t         q_cmd;
	logic [ADDR_BITS-1:0] q_addr;
	logic [SB-1:0]        q_left;
	logic [SB-1:0]        q_right;

	// position and classification
	logic [PB-1:0]        pos_q;
	logic [PB:0]          pos_sum;
	logic [IW-1:0]        idx;
	logic [IW:0]          idx_x;
	logic [IW:0]          frames_x;
	logic [FW-1:0]        frames_c;
	logic                 idx_in;
	logic                 lin_ok;
	logic                 cub_ok;
	csp_pkg::kind_t       kind_d;
	csp_pkg::kind_t       kind_q;
	logic                 inr_q;
	logic [FB-1:0]        mu_q;
	logic [ADDR_BITS-1:0] base_q;
	logic [2:0]           cnt_q;

	// lanes
	logic signed [SB-1:0] y_q    [2][4];
	logic signed [PW-1:0] prod_q [2];
	logic signed [PW-1:0] prod_d [2];
	logic signed [PW-1:0] rsum   [2];
	logic signed [W-1:0]  ye     [2][4];
	logic signed [W-1:0]  a0     [2];
	logic signed [W-1:0]  a1     [2];
	logic signed [W-1:0]  a2     [2];
	logic signed [W-1:0]  rnd    [2];
	logic signed [W-1:0]  opnd   [2];
	logic signed [W-1:0]  res    [2];
	logic signed [W-1:0]  sat    [2];
	logic signed [FB:0]   mu_s;

	// result register
	logic                 out_valid_q;
	logic signed [15:0]   left_q;
	logic signed [15:0]   right_q;
	logic                 inr_out_q;
	logic                 out_free;
	logic                 out_load;

	assign q_cmd   = csp_pkg::op_t'(q_data[ENTRY_BITS-1 -: 2]);
	assign q_addr  = q_data[2*SB +: ADDR_BITS];
	assign q_left  = q_data[SB +: SB];
	assign q_right = q_data[0 +: SB];

	assign out_free = !out_valid_q || !out_stall;
	assign rd_addr  = base_q + ADDR_BITS'(cnt_q);
	assign mu_s     = {1'b0, mu_q};

	always_comb begin
		frames_c = (32'(cfg.sample_frames) > 32'(SAMPLE_DEPTH)) ? FW'(SAMPLE_DEPTH)
			: cfg.sample_frames;
		idx      = pos_q[PB-1:FB];
		idx_x    = {1'b0, idx};
		frames_x = (IW+1)'(frames_c);
		idx_in   = idx_x < frames_x;
		lin_ok   = (idx_x + 1'b1) < frames_x;
		cub_ok   = (idx != '0) && ((idx_x + 2'd2) < frames_x);
		pos_sum  = {1'b0, pos_q} + (PB+1)'(cfg.position_step);
		if (!idx_in) begin
			kind_d = csp_pkg::KIND_ZERO;
		end else if (lin_ok) begin
			kind_d = cub_ok ? csp_pkg::KIND_CUBIC : csp_pkg::KIND_LINEAR;
		end else if (cfg.stereo_mode) begin
			kind_d = csp_pkg::KIND_ZERO;
		end else begin
			kind_d = csp_pkg::KIND_BARE;
		end
	end

	// per-lane datapath
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			for (int k = 0; k < 4; k++) begin
				ye[l][k] = W'(y_q[l][k]);
			end
			a0[l]   = ye[l][3] - ye[l][2] - ye[l][0] + ye[l][1];
			a1[l]   = ye[l][0] - ye[l][1] - a0[l];
			a2[l]   = ye[l][2] - ye[l][0];
			rsum[l] = prod_q[l] + RND_HALF;
			rnd[l]  = W'(rsum[l] >>> FB);
			case (state_q)
				csp_pkg::ST_STEP1: begin
					opnd[l] = (kind_q == csp_pkg::KIND_CUBIC) ? a0[l] : (ye[l][2] - ye[l][1]);
				end
				csp_pkg::ST_STEP2: begin
					opnd[l] = rnd[l] + a1[l];
				end
				csp_pkg::ST_STEP3: begin
					opnd[l] = rnd[l] + a2[l];
				end
				default: begin
					opnd[l] = '0;
				end
			endcase
			prod_d[l] = PW'(opnd[l]) * PW'(mu_s);
			case (kind_q)
				csp_pkg::KIND_CUBIC: begin
					res[l] = rnd[l] + ye[l][1];
				end
				csp_pkg::KIND_LINEAR: begin
					res[l] = rnd[l] + ye[l][1];
				end
				csp_pkg::KIND_BARE: begin
					res[l] = ye[l][1];
				end
				default: begin
					res[l] = '0;
				end
			endcase
			sat[l] = (res[l] > SAT_HI) ? SAT_HI : ((res[l] < SAT_LO) ? SAT_LO : res[l]);
		end
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		mem_we   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			csp_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_cmd == csp_pkg::OP_WRITE) begin
						mem_we = 1'b1;
					end else if (q_cmd == csp_pkg::OP_PRODUCE) begin
						state_d = (kind_d == csp_pkg::KIND_ZERO) ? csp_pkg::ST_FINISH
							: csp_pkg::ST_READ;
					end
				end
			end
			csp_pkg::ST_READ: begin
				if (cnt_q == 3'd4) begin
					state_d = (kind_q == csp_pkg::KIND_BARE) ? csp_pkg::ST_FINISH
						: csp_pkg::ST_STEP1;
				end
			end
			csp_pkg::ST_STEP1: begin
				state_d = (kind_q == csp_pkg::KIND_CUBIC) ? csp_pkg::ST_STEP2
					: csp_pkg::ST_FINISH;
			end
			csp_pkg::ST_STEP2: begin
				state_d = csp_pkg::ST_STEP3;
			end
			csp_pkg::ST_STEP3: begin
				state_d = csp_pkg::ST_FINISH;
			end
			csp_pkg::ST_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = csp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = csp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= csp_pkg::ST_IDLE;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop && q_cmd == csp_pkg::OP_RESTART) begin
				pos_q <= PB'(cfg.start_position);
			end else if (q_pop && q_cmd == csp_pkg::OP_PRODUCE) begin
				pos_q <= pos_sum[PB] ? '1 : pos_sum[PB-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_cmd == csp_pkg::OP_PRODUCE) begin
			kind_q <= kind_d;
			inr_q  <= idx_in;
			mu_q   <= pos_q[FB-1:0];
			base_q <= ADDR_BITS'(idx) - 1'b1;
			cnt_q  <= '0;
		end
		if (state_q == csp_pkg::ST_READ) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q != '0) begin
				for (int l = 0; l < 2; l++) begin
					for (int k = 0; k < 3; k++) begin
						y_q[l][k] <= y_q[l][k+1];
					end
				end
				y_q[0][3] <= rd_q[SB +: SB];
				y_q[1][3] <= rd_q[0 +: SB];
			end
		end
		if (state_q == csp_pkg::ST_STEP1 || state_q == csp_pkg::ST_STEP2
				|| state_q == csp_pkg::ST_STEP3) begin
			prod_q[0] <= prod_d[0];
			prod_q[1] <= prod_d[1];
		end
		if (out_load) begin
			left_q    <= 16'(sat[0]);
			right_q   <= cfg.stereo_mode ? 16'(sat[1]) : 16'(sat[0]);
			inr_out_q <= inr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[q_addr] <= {q_left, q_right};
		end
		rd_q <= mem[rd_addr];
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_q;
	assign right_out = right_q;
	assign in_range  = inr_out_q;

endmodule

@@ src/cubic_sample_player_top.sv @@
// ----------------------------------------------------------------------------
// cubic_sample_player_top
// Plays a stored mono or stereo sample at a fixed-point rate with four-point
// cubic interpolation. Input beats are decoded and queued (four entries), so
// the input keeps taking beats while the back end works, until the queue is
// full. The back end takes one command at a time: a frame write or a restart
// is taken straight from idle, an out-of-range produce or a stereo produce at
// the last frame goes straight to the result load, a linear produce at the
// first or the last frames reads the store, then multiplies and loads the
// result (a bare last mono frame skips the multiply), and a cubic produce
// makes four reads from the one sample store plus the registered read, then
// three multiply steps and the result load. A result waiting in the output
// register only holds the back end at its final step. The store is not
// cleared by reset; reading a frame never written gives undefined lanes.
module cubic_sample_player_top #(
	parameter int SAMPLE_DEPTH = csp_pkg::DEF_SAMPLE_DEPTH,
	parameter int SAMPLE_BITS  = csp_pkg::DEF_SAMPLE_BITS,
	parameter int FRAC_BITS    = csp_pkg::DEF_FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [csp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [csp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         opcode,
	input  logic [15:0]                        frame_address,
	input  logic signed [15:0]                 left_sample,
	input  logic signed [15:0]                 right_sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [15:0]                 left_out,
	output logic signed [15:0]                 right_out,
	output logic                               in_range
);

	localparam int ADDR_BITS  = $clog2(SAMPLE_DEPTH);
	localparam int ENTRY_BITS = 2 + ADDR_BITS + 2 * SAMPLE_BITS;

	csp_pkg::cfg_t         cfg_q;
	logic                  push_valid;
	logic [ENTRY_BITS-1:0] push_data;
	logic                  queue_full;
	logic                  q_valid;
	logic [ENTRY_BITS-1:0] q_data;
	logic                  q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_frames  <= csp_pkg::RST_SAMPLE_FRAMES;
			cfg_q.stereo_mode    <= csp_pkg::RST_STEREO_MODE;
			cfg_q.position_step  <= csp_pkg::RST_POSITION_STEP;
			cfg_q.start_position <= csp_pkg::RST_START_POSITION;
		end else if (cfg_write) begin
			case (csp_pkg::reg_index_t'(cfg_index))
				csp_pkg::REG_SAMPLE_FRAMES: begin
					cfg_q.sample_frames <= cfg_data[csp_pkg::FRAMES_BITS-1:0];
				end
				csp_pkg::REG_STEREO_MODE: begin
					cfg_q.stereo_mode <= cfg_data[0];
				end
				csp_pkg::REG_POSITION_STEP: begin
					cfg_q.position_step <= cfg_data[31:0];
				end
				csp_pkg::REG_START_POSITION: begin
					cfg_q.start_position <= cfg_data[31:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	csp_front #(
		.SAMPLE_DEPTH (SAMPLE_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.ADDR_BITS    (ADDR_BITS),
		.ENTRY_BITS   (ENTRY_BITS)
	) u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.frame_address (frame_address),
		.left_sample   (left_sample),
		.right_sample  (right_sample),
		.queue_full    (queue_full),
		.push_valid    (push_valid),
		.push_data     (push_data)
	);

	csp_fifo #(
		.WIDTH (ENTRY_BITS)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_data)
	);

	csp_back #(
		.SAMPLE_DEPTH (SAMPLE_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.FRAC_BITS    (FRAC_BITS),
		.ADDR_BITS    (ADDR_BITS),
		.ENTRY_BITS   (ENTRY_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.left_out  (left_out),
		.right_out (right_out),
		.in_range  (in_range)
	);

endmodule

@@ verif/cubic_sample_player_top_tb.sv @@
// ----------------------------------------------------------------------------
// cubic_sample_player_top_tb
// Drives frame writes, restarts and produce beats into the sample player and
// predicts every output frame from its own copy of the store, the position
// and the registers. Each phase loads a small window of frames, sets the
// registers while the block is idle and then plays through the window with
// random beats, so every read falls on a frame that was written. One phase
// runs the position into saturation, and one holds the output off for a long
// stretch and later pauses the input until every frame has come out.
// ----------------------------------------------------------------------------
module cubic_sample_player_top_tb;

	localparam logic [1:0] OP_IGNORED  = 2'd3;
	localparam int         ITEM_TARGET = 1150;
	localparam int         FRAC        = csp_pkg::DEF_FRAC_BITS;
	localparam longint     HALF_LSB    = 64'sd1 <<< (FRAC - 1);
	localparam longint     FULL_POS    = 40'hff_ffff_ffff;

	typedef struct {
		logic signed [15:0] left_val;
		logic signed [15:0] right_val;
		logic               ok;
	} out_frame_t;

	class playback_checker;
		shortint      lane_l [0:65535];
		shortint      lane_r [0:65535];
		logic [39:0]  position;
		logic [16:0]  frames;
		logic         stereo;
		logic [31:0]  step;
		logic [31:0]  start_pos;
		out_frame_t   pending_frames[$];
		int unsigned  mismatches;

		function new();
			position   = '0;
			frames     = csp_pkg::RST_SAMPLE_FRAMES;
			stereo     = csp_pkg::RST_STEREO_MODE;
			step       = csp_pkg::RST_POSITION_STEP;
			start_pos  = csp_pkg::RST_START_POSITION;
			mismatches = 0;
		endfunction

		function void set_register(csp_pkg::reg_index_t idx, logic [31:0] value);
			case (idx)
				csp_pkg::REG_SAMPLE_FRAMES:  frames = value[16:0];
				csp_pkg::REG_STEREO_MODE:    stereo = value[0];
				csp_pkg::REG_POSITION_STEP:  step = value;
				csp_pkg::REG_START_POSITION: start_pos = value;
				default: ;
			endcase
		endfunction

		function longint round_q(longint x);
			return (x + HALF_LSB) >>> FRAC;
		endfunction

		function logic signed [15:0] clip(longint x);
			if (x > 32767)
				return 16'sh7fff;
			if (x < -32768)
				return 16'sh8000;
			return x[15:0];
		endfunction

		function longint lane_at(bit right_lane, int unsigned i);
			return right_lane ? lane_r[i] : lane_l[i];
		endfunction

		function longint interpolate(bit right_lane, int unsigned idx, int unsigned n,
				longint mu);
			longint y0, y1, y2, y3, a0, a1, a2, acc;
			y1 = lane_at(right_lane, idx);
			y2 = lane_at(right_lane, idx + 1);
			// linear where a neighbour is missing
			if (idx == 0 || idx + 2 >= n)
				return y1 + round_q((y2 - y1) * mu);
			y0 = lane_at(right_lane, idx - 1);
			y3 = lane_at(right_lane, idx + 2);
			a0 = y3 - y2 - y0 + y1;
			a1 = y0 - y1 - a0;
			a2 = y2 - y0;
			acc = round_q(a0 * mu) + a1;
			acc = round_q(acc * mu) + a2;
			return round_q(acc * mu) + y1;
		endfunction

		function void take_beat(logic [1:0] op, logic [15:0] addr,
				logic signed [15:0] l, logic signed [15:0] r);
			out_frame_t  f;
			int unsigned n, idx;
			longint      mu, lv, rv;
			logic [40:0] sum;
			case (op)
				csp_pkg::OP_WRITE: begin
					lane_l[addr] = l;
					lane_r[addr] = r;
				end
				csp_pkg::OP_RESTART: position = {8'd0, start_pos};
				csp_pkg::OP_PRODUCE: begin
					n   = (frames > 17'd65536) ? 65536 : frames;
					idx = position[39:FRAC];
					mu  = position[FRAC-1:0];
					lv  = 0;
					rv  = 0;
					f.ok = 1'b0;
					if (idx < n) begin
						f.ok = 1'b1;
						if (idx + 1 < n) begin
							lv = interpolate(1'b0, idx, n, mu);
							rv = stereo ? interpolate(1'b1, idx, n, mu) : lv;
						end else if (!stereo) begin
							// bare last mono frame
							lv = lane_l[idx];
							rv = lv;
						end
					end
					f.left_val  = clip(lv);
					f.right_val = clip(rv);
					pending_frames.insert(pending_frames.size(), f);
					sum = {1'b0, position} + step;
					position = sum[40] ? FULL_POS[39:0] : sum[39:0];
				end
				default: ;
			endcase
		endfunction

		function void check_frame(logic signed [15:0] l, logic signed [15:0] r, logic ok);
			out_frame_t f;
			if (pending_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output beat: l=%0d r=%0d in_range=%0b", l, r, ok);
			end else begin
				f = pending_frames.pop_front();
				if (l !== f.left_val || r !== f.right_val || ok !== f.ok) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected l=%0d r=%0d in_range=%0b, got l=%0d r=%0d in_range=%0b",
							f.left_val, f.right_val, f.ok, l, r, ok);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         opcode = '0;
	logic [15:0]        frame_address = '0;
	logic signed [15:0] left_sample = '0;
	logic signed [15:0] right_sample = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic               in_range;

	playback_checker board;
	int unsigned     beats_sent = 0;
	int unsigned     tx_idle = 34;
	int unsigned     rx_idle = 69;
	int unsigned     rx_hold_cycles = 0;

	cubic_sample_player_top dut (.*);

	always #1 clk = ~clk;

	initial begin
		#1000000;
		$display("status: fail");
		$finish;
	end

	// output side stalls, with one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			board.check_frame(left_out, right_out, in_range);

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_beat(input logic [1:0] op, input logic [15:0] addr,
			input logic [15:0] l, input logic [15:0] r);
		if (beats_sent >= 760) begin
			tx_idle = 0;
			rx_idle = 0;
		end else if (beats_sent >= 380) begin
			tx_idle = 69;
			rx_idle = 34;
		end
		if ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle)
				@(posedge clk);
		end
		in_valid      <= 1'b1;
		opcode        <= op;
		frame_address <= addr;
		left_sample   <= l;
		right_sample  <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.take_beat(op, addr, l, r);
		if (op != OP_IGNORED)
			beats_sent++;
	endtask

	// drop valid and wait until every frame is out and the queue has emptied
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending_frames.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
	endtask

	task automatic write_register(input csp_pkg::reg_index_t idx, input logic [31:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		board.set_register(idx, value);
	endtask

	task automatic configure(input logic [16:0] nframes, input logic stereo_on,
			input logic [31:0] step, input logic [31:0] start);
		logic [31:0] junk;
		junk = $urandom;
		write_register(csp_pkg::REG_SAMPLE_FRAMES, {junk[31:17], nframes});
		write_register(csp_pkg::REG_STEREO_MODE, {junk[30:0], stereo_on});
		write_register(csp_pkg::REG_POSITION_STEP, step);
		write_register(csp_pkg::REG_START_POSITION, start);
		cfg_write <= 1'b0;
	endtask

	task automatic run_phase(input int unsigned nr);
		int unsigned span, base, nframes, idx, count, roll, a, i;
		logic [31:0] step, start, frac;
		logic [15:0] addr;
		logic        stereo_on;
		bit          saturating;
		saturating = (nr == 2);
		span = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
		base = 0;
		nframes = span;
		case ($urandom_range(4))
			3: begin
				// window at the top of the store
				base = 65536 - span;
				case ($urandom_range(2))
					0: nframes = 65536;
					1: nframes = 17'h1ffff;
					default: nframes = $urandom_range(65537, 131071);
				endcase
			end
			4: begin
				base = $urandom_range(1, 65535 - span);
				nframes = base + span;
			end
			default: if ($urandom_range(9) == 0) nframes = 0;
		endcase
		case ($urandom_range(7))
			0: step = 32'd0;
			1: step = 32'hffff_ffff;
			2: step = 32'h0001_0000;
			3, 4: step = $urandom_range(1, 65535);
			5, 6: step = $urandom_range(65537, 32'h0002_8000);
			default: step = $urandom;
		endcase
		idx = $urandom_range(base == 0 ? 0 : base + 1, base + span + 1);
		if (idx > 65535)
			idx = 65535;
		frac = $urandom;
		start = {idx[15:0], frac[15:0]};
		roll = $urandom_range(5);
		if (roll == 0)
			start = 32'hffff_ffff;
		else if (roll == 1)
			start[15:0] = '0;
		else if (roll == 2 && base == 0)
			start = '0;
		stereo_on = $urandom_range(1);
		count = $urandom_range(30, 90);
		if (nr == 1)
			count = 90;
		if (saturating) begin
			step  = 32'hffff_ffff;
			start = 32'hffff_ffff;
			count = 280;
		end

		settle();
		configure(nframes[16:0], stereo_on, step, start);
		for (a = base; a < base + span; a++)
			send_beat(csp_pkg::OP_WRITE, a[15:0], pick_sample(), pick_sample());
		send_beat(csp_pkg::OP_RESTART, $urandom, $urandom, $urandom);
		if (nr == 1)
			rx_hold_cycles = 300;

		for (i = 0; i < count; i++) begin
			if (nr == 1 && i == count / 2)
				settle();
			roll = $urandom_range(99);
			if (saturating && roll < 90)
				roll = 0;
			if (roll < 62) begin
				send_beat(csp_pkg::OP_PRODUCE, $urandom, $urandom, $urandom);
			end else if (roll < 76) begin
				send_beat(csp_pkg::OP_WRITE, base + $urandom_range(span - 1), pick_sample(),
					pick_sample());
			end else if (roll < 86) begin
				send_beat(csp_pkg::OP_RESTART, $urandom, $urandom, $urandom);
			end else if (roll < 93) begin
				case ($urandom_range(3))
					0: addr = 16'h0000;
					1: addr = 16'hffff;
					default: addr = $urandom;
				endcase
				send_beat(csp_pkg::OP_WRITE, addr, pick_sample(), pick_sample());
			end else begin
				send_beat(OP_IGNORED, $urandom, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		int unsigned phase_nr, k;
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty sample after reset, then an unused opcode
		send_beat(csp_pkg::OP_PRODUCE, 16'h0000, 16'h0000, 16'h0000);
		send_beat(OP_IGNORED, 16'hffff, 16'hffff, 16'hffff);
		settle();
		configure(17'd6, 1'b1, 32'h0000_8000, 32'h0000_0000);
		// full-scale frames that overshoot the cubic, plus the top address
		send_beat(csp_pkg::OP_WRITE, 16'd0, 16'h0000, 16'h0000);
		send_beat(csp_pkg::OP_WRITE, 16'd1, 16'h8000, 16'h7fff);
		send_beat(csp_pkg::OP_WRITE, 16'd2, 16'h7fff, 16'h8000);
		send_beat(csp_pkg::OP_WRITE, 16'd3, 16'h7fff, 16'h8000);
		send_beat(csp_pkg::OP_WRITE, 16'd4, 16'h8000, 16'h7fff);
		send_beat(csp_pkg::OP_WRITE, 16'd5, 16'h7fff, 16'h8000);
		send_beat(csp_pkg::OP_WRITE, 16'hffff, 16'hffff, 16'h0001);
		send_beat(csp_pkg::OP_RESTART, 16'h0000, 16'h0000, 16'h0000);
		// half-frame steps: linear edge, cubic, linear end, last frame, out of range
		for (k = 0; k < 13; k++)
			send_beat(csp_pkg::OP_PRODUCE, 16'h0000, 16'h0000, 16'h0000);

		phase_nr = 0;
		while (beats_sent < ITEM_TARGET) begin
			run_phase(phase_nr);
			phase_nr++;
		end

		settle();
		if (board.mismatches == 0 && board.pending_frames.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ cubic_sample_player_top.f @@
src/csp_pkg.sv
src/csp_front.sv
src/csp_fifo.sv
src/csp_back.sv
src/cubic_sample_player_top.sv
verif/cubic_sample_player_top_tb.sv
